>>> src/wbss_pkg.sv
// Package for the wildcard byte signature scanner.
// Holds default parameter values, configuration register indexes and reset values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wbss_pkg;

    // Default sizing of the top level.
    localparam int PATTERN_BYTES_DEF = 16;
    localparam int ADDRESS_BITS_DEF  = 48;

    // The signature registers hold this many bytes.
    localparam int SIG_BYTES = 16;

    // Configuration channel widths.
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 64;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_PATTERN_LOW  = 3'd0,
        CFG_PATTERN_HIGH = 3'd1,
        CFG_CARE_MASK    = 3'd2,
        CFG_PATTERN_LEN  = 3'd3,
        CFG_RESULT_OFS   = 3'd4,
        CFG_FIND_ALL     = 3'd5
    } t_cfg_index;

    // Register reset values.
    localparam logic [63:0] RST_PATTERN_LOW  = 64'h0;
    localparam logic [63:0] RST_PATTERN_HIGH = 64'h0;
    localparam logic [15:0] RST_CARE_MASK    = 16'hFFFF;
    localparam logic [4:0]  RST_PATTERN_LEN  = 5'd1;
    localparam logic [31:0] RST_RESULT_OFS   = 32'h0;
    localparam logic        RST_FIND_ALL     = 1'b0;

endpackage

`default_nettype wire

>>> src/wildcard_byte_signature_scanner_unit.sv
// Top level of the wildcard byte signature scanner.
// Depends on wbss_pkg for defaults, register indexes and reset values.
//
// Usage:
// Bytes enter on the s_axis channel, one per transaction, with their address;
// s_axis_tlast marks the final byte of a scanned region. Results leave on the
// m_axis channel: m_axis_tuser is the match flag, m_axis_tdata the match start
// address plus the signed offset, m_axis_tlast marks the result for the last
// byte. A byte yields a result only when a reported match ends at it or when
// it is the last byte; other bytes yield none.
// Registers are written on the cfg channel (index, data), which is always
// ready; write them only while no byte is in flight.
// A byte's result goes from the input register to the output register as the
// byte advances. Throughput is one byte per cycle unless the receiver stalls:
// the input register, the parallel window compare and the output register form
// a two-stage pipeline. When the receiver stalls, the output register holds its
// result and the input register holds the next byte; bytes without a result
// still pass. Synchronous active-low reset empties both stages, restores
// register defaults and starts a new scan.
`timescale 1ns / 1ps
`default_nettype none

module wildcard_byte_signature_scanner_unit #(
    parameter int PATTERN_BYTES = wbss_pkg::PATTERN_BYTES_DEF,
    parameter int ADDRESS_BITS  = wbss_pkg::ADDRESS_BITS_DEF
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    // Input stream; tdata fields from bit 0: data_byte[7:0], byte_address.
    input  wire logic                                        s_axis_tvalid,
    output      logic                                        s_axis_tready,
    input  wire logic [((8+ADDRESS_BITS+7)/8)*8-1:0]          s_axis_tdata,
    input  wire logic                                        s_axis_tlast,
    // Result stream; tdata fields from bit 0: match_address; tuser: match_found.
    output      logic                                        m_axis_tvalid,
    input  wire logic                                        m_axis_tready,
    output      logic [((ADDRESS_BITS+7)/8)*8-1:0]            m_axis_tdata,
    output      logic                                        m_axis_tuser,
    output      logic                                        m_axis_tlast,
    // Configuration write channel.
    input  wire logic                                        i_cfg_valid,
    output      logic                                        o_cfg_ready,
    input  wire logic [wbss_pkg::CFG_INDEX_BITS-1:0]         i_cfg_index,
    input  wire logic [wbss_pkg::CFG_DATA_BITS-1:0]          i_cfg_data
);

    localparam int OUT_W = ((ADDRESS_BITS + 7) / 8) * 8;
    localparam int CAP   = (PATTERN_BYTES < wbss_pkg::SIG_BYTES) ?
                           PATTERN_BYTES : wbss_pkg::SIG_BYTES;
    localparam int CW    = $clog2(PATTERN_BYTES + 1);
    localparam int SB    = wbss_pkg::SIG_BYTES;

    // Configuration registers.
    logic [63:0]        r_pat_lo;
    logic [63:0]        r_pat_hi;
    logic [15:0]        r_care;
    logic [4:0]         r_len;
    logic signed [31:0] r_offset;
    logic               r_find_all;

    // Input register.
    logic                    r_in_valid;
    logic [7:0]              r_in_byte;
    logic [ADDRESS_BITS-1:0] r_in_addr;
    logic                    r_in_last;

    // Scan state.
    logic [7:0]    r_window [PATTERN_BYTES];
    logic [7:0]    n_window [PATTERN_BYTES];
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_hit_taken;
    logic          n_hit_taken;

    // Output register.
    logic                    r_out_valid;
    logic                    r_out_match;
    logic [ADDRESS_BITS-1:0] r_out_addr;
    logic                    r_out_last;

    logic [4:0]              w_len;
    logic [CW-1:0]           w_count_inc;
    logic [7:0]              w_recent [SB];
    logic [7:0]              w_sig [SB];
    logic                    w_match;
    logic                    w_hit;
    logic                    w_produce;
    logic                    w_adv;
    logic                    w_accept;
    logic [63:0]             w_sum;
    logic [ADDRESS_BITS-1:0] w_where;

    assign o_cfg_ready = 1'b1;

    // Active length: zero counts as one, clipped to the smaller of window depth and signature size.
    always_comb begin
        if (r_len == 5'd0) begin
            w_len = 5'd1;
        end else if (r_len > 5'(CAP)) begin
            w_len = 5'(CAP);
        end else begin
            w_len = r_len;
        end
    end

    always_comb begin
        n_window[0] = r_in_byte;
        for (int k = 1; k < PATTERN_BYTES; k++) begin
            n_window[k] = r_window[k-1];
        end
    end

    genvar g;
    generate
        for (g = 0; g < SB; g++) begin : g_lane
            if (g < CAP) begin : g_used
                assign w_recent[g] = n_window[g];
            end else begin : g_unused
                assign w_recent[g] = 8'h00;
            end
            assign w_sig[g] = (g < 8) ? r_pat_lo[8*(g%8) +: 8] : r_pat_hi[8*(g%8) +: 8];
        end
    endgenerate

    // Signature byte i lines up with the byte taken len-1-i bytes ago.
    always_comb begin
        logic [4:0] v_idx;
        w_match = 1'b1;
        for (int i = 0; i < SB; i++) begin
            v_idx = w_len - 5'd1 - 5'(i);
            if ((5'(i) < w_len) && r_care[i] && (w_recent[v_idx[3:0]] != w_sig[i])) begin
                w_match = 1'b0;
            end
        end
    end

    assign w_count_inc = (r_count < CW'(PATTERN_BYTES)) ? r_count + CW'(1) : r_count;
    assign w_hit       = (8'(w_count_inc) >= 8'(w_len)) && w_match &&
                         (r_find_all || !r_hit_taken);
    assign w_produce   = w_hit || r_in_last;

    assign w_sum   = 64'(r_in_addr) - 64'(w_len - 5'd1) + 64'(r_offset);
    assign w_where = w_hit ? w_sum[ADDRESS_BITS-1:0] : '0;

    always_comb begin
        n_count     = w_count_inc;
        n_hit_taken = r_hit_taken || w_hit;
        if (w_hit && r_find_all) begin
            n_count = '0;
        end
        if (r_in_last) begin
            n_count     = '0;
            n_hit_taken = 1'b0;
        end
    end

    // A byte without a result never waits for the output register.
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready || !w_produce);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo    <= wbss_pkg::RST_PATTERN_LOW;
            r_pat_hi    <= wbss_pkg::RST_PATTERN_HIGH;
            r_care      <= wbss_pkg::RST_CARE_MASK;
            r_len       <= wbss_pkg::RST_PATTERN_LEN;
            r_offset    <= wbss_pkg::RST_RESULT_OFS;
            r_find_all  <= wbss_pkg::RST_FIND_ALL;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                wbss_pkg::CFG_PATTERN_LOW:  r_pat_lo   <= i_cfg_data;
                wbss_pkg::CFG_PATTERN_HIGH: r_pat_hi   <= i_cfg_data;
                wbss_pkg::CFG_CARE_MASK:    r_care     <= i_cfg_data[15:0];
                wbss_pkg::CFG_PATTERN_LEN:  r_len      <= i_cfg_data[4:0];
                wbss_pkg::CFG_RESULT_OFS:   r_offset   <= i_cfg_data[31:0];
                wbss_pkg::CFG_FIND_ALL:     r_find_all <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_count     <= '0;
            r_hit_taken <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_count     <= n_count;
                r_hit_taken <= n_hit_taken;
            end
            if (w_adv && w_produce) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= s_axis_tdata[7:0];
            r_in_addr <= s_axis_tdata[8 +: ADDRESS_BITS];
            r_in_last <= s_axis_tlast;
        end
        if (w_adv) begin
            r_window <= n_window;
        end
        if (w_adv && w_produce) begin
            r_out_match <= w_hit;
            r_out_addr  <= w_where;
            r_out_last  <= r_in_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'(r_out_addr);
    assign m_axis_tuser  = r_out_match;
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

>>> src/wbss_checker.sv
// Port-level checker for the wildcard byte signature scanner, and its bind.
// Depends on wbss_pkg and on the top level wildcard_byte_signature_scanner_unit.
`timescale 1ns / 1ps
`default_nettype none

module wbss_checker #(
    parameter int PATTERN_BYTES = wbss_pkg::PATTERN_BYTES_DEF,
    parameter int ADDRESS_BITS  = wbss_pkg::ADDRESS_BITS_DEF
) (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                s_axis_tvalid,
    input wire logic                                s_axis_tready,
    input wire logic [((8+ADDRESS_BITS+7)/8)*8-1:0] s_axis_tdata,
    input wire logic                                s_axis_tlast,
    input wire logic                                m_axis_tvalid,
    input wire logic                                m_axis_tready,
    input wire logic [((ADDRESS_BITS+7)/8)*8-1:0]   m_axis_tdata,
    input wire logic                                m_axis_tuser,
    input wire logic                                m_axis_tlast,
    input wire logic                                i_cfg_valid,
    input wire logic                                o_cfg_ready,
    input wire logic [wbss_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input wire logic [wbss_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    // The output stage comes out of reset empty.
    a_empty_after_reset: assert property (@(posedge i_clk)
        ($past(i_rst_n) == 1'b0) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

    // A result without a match exists only for the last byte of a scan.
    a_nomatch_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
        else $error("result with no match and no end marker");

    // Without a match the address field reads zero.
    a_nomatch_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("nonzero address on a result without match");

    // A stalled result holds still.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
         $stable(m_axis_tlast)))
        else $error("stalled result changed");

endmodule

bind wildcard_byte_signature_scanner_unit wbss_checker #(
    .PATTERN_BYTES(PATTERN_BYTES),
    .ADDRESS_BITS (ADDRESS_BITS)
) u_wbss_checker (.*);

`default_nettype wire
